FILE: design/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Shared types, constants and helpers of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package qfa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int N_CELLS   = NUM_W;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,  CMD_SUB = 4'd1,  CMD_MUL = 4'd2,  CMD_DIV = 4'd3,
    CMD_GT   = 4'd4,  CMD_LT  = 4'd5,  CMD_GE  = 4'd6,  CMD_LE  = 4'd7,
    CMD_EQ   = 4'd8,  CMD_NE  = 4'd9,  CMD_MIN = 4'd10, CMD_MAX = 4'd11,
    CMD_INC  = 4'd12, CMD_DEC = 4'd13, CMD_I2F = 4'd14, CMD_F2I = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } stat_t;

  // One transaction as it travels down the divider chain
  typedef struct packed {
    cmd_t                     cmd;
    logic                     neg;
    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        res;
    logic                     flag;
    stat_t                    status;
    logic [DATA_W-1:0]        rem;
    logic [NUM_W-1:0]         numq;
    logic [DATA_W-1:0]        den;
  } cell_t;

  localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  // Clamp a one-bit-grown sum; bit DATA_W of the result flags saturation
  function automatic logic [DATA_W:0] clamp_sum(input logic [DATA_W:0] x);
    logic ovf;
    ovf = x[DATA_W] ^ x[DATA_W-1];
    if (ovf) begin
      clamp_sum = {1'b1, (x[DATA_W] ? MIN_VAL : MAX_VAL)};
    end else begin
      clamp_sum = {1'b0, x[DATA_W-1:0]};
    end
  endfunction

  // Apply a sign to a magnitude and clamp; bit DATA_W flags saturation
  function automatic logic [DATA_W:0] sat_mag(input logic [PROD_W-1:0] m,
                                               input logic neg);
    logic [PROD_W-1:0] lim;
    lim = {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}} + {{(PROD_W-1){1'b0}}, neg};
    if (m > lim) begin
      sat_mag = {1'b1, (neg ? MIN_VAL : MAX_VAL)};
    end else if (neg) begin
      sat_mag = {1'b0, (DATA_W'(0) - m[DATA_W-1:0])};
    end else begin
      sat_mag = {1'b0, m[DATA_W-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/qfa_front.sv
// ----------------------------------------------------------------------------
// qfa_front
// Decode a transaction: direct-result commands, the product, divider setup.
// ----------------------------------------------------------------------------
`default_nettype none
module qfa_front import qfa_pkg::*; (
  input  logic [3:0]               cmd,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output cell_t                    dat
);

  logic [DATA_W:0]    sum_w, dif_w, inc_w, dec_w;
  logic [DATA_W:0]    sum_c, dif_c, inc_c, dec_c;
  logic [DATA_W-1:0]  mag_a, mag_b;
  logic [FRAC_BITS:0] top_a;
  logic               i2f_ok;
  logic [DATA_W-1:0]  res;
  logic               flag;
  stat_t              status;

  // Grown sums and their clamped forms
  assign sum_w = {operand_a[DATA_W-1], operand_a} + {operand_b[DATA_W-1], operand_b};
  assign dif_w = {operand_a[DATA_W-1], operand_a} - {operand_b[DATA_W-1], operand_b};
  assign inc_w = {operand_a[DATA_W-1], operand_a} + (DATA_W+1)'(1);
  assign dec_w = {operand_a[DATA_W-1], operand_a} - (DATA_W+1)'(1);
  assign sum_c = clamp_sum(sum_w);
  assign dif_c = clamp_sum(dif_w);
  assign inc_c = clamp_sum(inc_w);
  assign dec_c = clamp_sum(dec_w);

  // Integer to fixed fits only when the bits shifted out match the sign
  assign top_a  = operand_a[DATA_W-1 -: FRAC_BITS+1];
  assign i2f_ok = (&top_a) || (~|top_a);

  assign mag_a = operand_a[DATA_W-1] ? DATA_W'(0) - operand_a : operand_a;
  assign mag_b = operand_b[DATA_W-1] ? DATA_W'(0) - operand_b : operand_b;

  // Select the result of the commands that are resolved here
  always_comb begin
    res    = '0;
    flag   = 1'b0;
    status = STAT_OK;
    unique case (cmd_t'(cmd))
      CMD_ADD: begin
        res    = sum_c[DATA_W-1:0];
        status = sum_c[DATA_W] ? STAT_SAT : STAT_OK;
      end
      CMD_SUB: begin
        res    = dif_c[DATA_W-1:0];
        status = dif_c[DATA_W] ? STAT_SAT : STAT_OK;
      end
      CMD_MUL: ;
      CMD_DIV: status = (operand_b == '0) ? STAT_DIV0 : STAT_OK;
      CMD_GT:  flag = operand_a > operand_b;
      CMD_LT:  flag = operand_a < operand_b;
      CMD_GE:  flag = operand_a >= operand_b;
      CMD_LE:  flag = operand_a <= operand_b;
      CMD_EQ:  flag = operand_a == operand_b;
      CMD_NE:  flag = operand_a != operand_b;
      CMD_MIN: res  = (operand_b < operand_a) ? operand_b : operand_a;
      CMD_MAX: res  = (operand_a < operand_b) ? operand_b : operand_a;
      CMD_INC: begin
        res    = inc_c[DATA_W-1:0];
        status = inc_c[DATA_W] ? STAT_SAT : STAT_OK;
      end
      CMD_DEC: begin
        res    = dec_c[DATA_W-1:0];
        status = dec_c[DATA_W] ? STAT_SAT : STAT_OK;
      end
      CMD_I2F: begin
        if (i2f_ok) begin
          res = {operand_a[DATA_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end else begin
          res    = operand_a[DATA_W-1] ? MIN_VAL : MAX_VAL;
          status = STAT_SAT;
        end
      end
      CMD_F2I: res = operand_a >>> FRAC_BITS;
    endcase
  end

  // Pack the transaction and seed the divider with |a| << FRAC_BITS over |b|
  always_comb begin
    dat        = '0;
    dat.cmd    = cmd_t'(cmd);
    dat.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    dat.prod   = PROD_W'(operand_a) * PROD_W'(operand_b);
    dat.res    = res;
    dat.flag   = flag;
    dat.status = status;
    dat.rem    = '0;
    dat.numq   = {mag_a, {FRAC_BITS{1'b0}}};
    dat.den    = mag_b;
  end

endmodule
`default_nettype wire

FILE: design/qfa_cell.sv
// ----------------------------------------------------------------------------
// qfa_cell
// One restoring-division cell: one quotient bit, one pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none
module qfa_cell import qfa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_vld,
  input  cell_t up_dat,
  input  logic  dn_adv,
  output logic  adv,
  output logic  vld_r,
  output cell_t dat_r
);

  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            ge;
  cell_t           dat_nxt;
  logic            vld_nxt;

  // Shift in the next numerator bit and try the subtract
  assign trial = {up_dat.rem, up_dat.numq[NUM_W-1]};
  assign ge    = trial >= {1'b0, up_dat.den};
  assign diff  = trial - {1'b0, up_dat.den};

  always_comb begin
    dat_nxt      = up_dat;
    dat_nxt.rem  = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    dat_nxt.numq = {up_dat.numq[NUM_W-2:0], ge};
  end

  // Load when empty or when the neighbor takes the current transaction
  assign adv     = !vld_r || dn_adv;
  assign vld_nxt = adv ? up_vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/qfa_back.sv
// ----------------------------------------------------------------------------
// qfa_back
// Finish a transaction: round and clamp multiply and divide results.
// ----------------------------------------------------------------------------
`default_nettype none
module qfa_back import qfa_pkg::*; (
  input  cell_t             dat,
  output logic [DATA_W-1:0] res,
  output logic              flag,
  output stat_t             status
);

  logic [PROD_W-1:0] pmag, prnd;
  logic [DATA_W:0]   mul_c, div_c;
  logic              rbit;
  logic [NUM_W:0]    qr;

  // Product: magnitude, add half an LSB, drop the fraction
  assign pmag  = dat.prod[PROD_W-1] ? PROD_W'(0) - dat.prod : dat.prod;
  assign prnd  = (pmag + (PROD_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
  assign mul_c = sat_mag(prnd, dat.prod[PROD_W-1]);

  // Quotient: round up when twice the remainder reaches the divisor
  assign rbit  = {dat.rem, 1'b0} >= {1'b0, dat.den};
  assign qr    = {1'b0, dat.numq} + {{NUM_W{1'b0}}, rbit};
  assign div_c = sat_mag({{(PROD_W-NUM_W-1){1'b0}}, qr}, dat.neg);

  always_comb begin
    res    = dat.res;
    flag   = dat.flag;
    status = dat.status;
    if (dat.cmd == CMD_MUL) begin
      res    = mul_c[DATA_W-1:0];
      status = mul_c[DATA_W] ? STAT_SAT : STAT_OK;
    end else if (dat.cmd == CMD_DIV && dat.status != STAT_DIV0) begin
      res    = div_c[DATA_W-1:0];
      status = div_c[DATA_W] ? STAT_SAT : STAT_OK;
    end
  end

endmodule
`default_nettype wire

FILE: design/q24_8_fixed_point_alu_core.sv
// Q24.8 fixed-point ALU. Every transaction passes a fixed pipeline of 41
// registers: one row of 40 division cells (one quotient bit each, numerator
// width 32 + FRAC_BITS) plus the output register; a new transaction is taken
// every cycle while in_stall is low.
// Stages advance independently, so bubbles close up while the output stalls.
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_core
// Top level: decode, chain of division cells, rounding, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module q24_8_fixed_point_alu_core import qfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_compare_flag,
  output logic [1:0]               out_status
);

  cell_t             cdat [N_CELLS+1];
  logic              cvld [N_CELLS+1];
  logic              cadv [N_CELLS+1];
  logic [DATA_W-1:0] fin_res;
  logic              fin_flag;
  stat_t             fin_status;
  logic              out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0] out_res_r;
  logic              out_flag_r;
  stat_t             out_stat_r;

  // Decode the incoming transaction
  qfa_front u_front (
    .cmd       (in_cmd),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .dat       (cdat[0])
  );
  assign cvld[0] = in_valid;
  assign in_stall = !cadv[0];

  // Row of division cells
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    qfa_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (cvld[i]),
      .up_dat (cdat[i]),
      .dn_adv (cadv[i+1]),
      .adv    (cadv[i]),
      .vld_r  (cvld[i+1]),
      .dat_r  (cdat[i+1])
    );
  end

  qfa_back u_back (
    .dat    (cdat[N_CELLS]),
    .res    (fin_res),
    .flag   (fin_flag),
    .status (fin_status)
  );

  // Output register
  assign cadv[N_CELLS] = !out_vld_r || !out_stall;
  assign out_vld_nxt   = cadv[N_CELLS] ? cvld[N_CELLS] : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cadv[N_CELLS]) begin
      out_res_r  <= fin_res;
      out_flag_r <= fin_flag;
      out_stat_r <= fin_status;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_value = out_res_r;
  assign out_compare_flag = out_flag_r;
  assign out_status       = out_stat_r;

`ifndef SYNTH
  a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_flag |-> out_status == STAT_OK)
    else $error("compare result with nonzero status");
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_DIV0 |-> out_result_value == '0 && !out_compare_flag)
    else $error("divide by zero with nonzero payload");
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output drains");
`endif

endmodule
`default_nettype wire
